@@ sv/rlcs_pkg.sv @@
package rlcs_pkg;

  localparam int MAX_LINE_DEF = 255;
  localparam int ID_LEN_DEF   = 5;

  localparam int NODE_ID_W  = 40;
  localparam int WAIT_W     = 16;
  localparam int ID_EXT_W   = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = NODE_ID_W;

  localparam logic [NODE_ID_W-1:0] NODE_ID_RST = 40'h4730345F30;
  localparam logic [WAIT_W-1:0]    WAIT_RST    = 16'd2000;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT    = 1'b1;

  localparam logic [7:0] NL_CHAR  = 8'd10;
  localparam logic [7:0] SEP_CHAR = 8'd95;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_STAMP = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       to_ring;
    logic       last;
    logic       err;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic line_active;
    logic awaiting;
  } front_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'd48 + {4'd0, v}) : (8'd55 + {4'd0, v});
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    hex_val = 5'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      d = c - 8'd48;
      hex_val = {1'b1, d[3:0]};
    end else if (c >= 8'd65 && c <= 8'd70) begin
      d = c - 8'd55;
      hex_val = {1'b1, d[3:0]};
    end else if (c >= 8'd97 && c <= 8'd102) begin
      d = c - 8'd87;
      hex_val = {1'b1, d[3:0]};
    end
  endfunction

endpackage

@@ sv/rlcs_in_if.sv @@
interface rlcs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic       from_ring;

  modport source (output valid, action, rx_byte, from_ring, input ready);
  modport sink   (input valid, action, rx_byte, from_ring, output ready);
endinterface

@@ sv/rlcs_out_if.sv @@
interface rlcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       to_ring;
  logic       last;
  logic       checksum_error;

  modport source (output valid, out_byte, to_ring, last, checksum_error, input ready);
  modport sink   (input valid, out_byte, to_ring, last, checksum_error, output ready);
endinterface

@@ sv/rlcs_cfg_if.sv @@
interface rlcs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rlcs_pkg::CFG_IDX_W-1:0]     index;
  logic [rlcs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/ring_line_checksum_stamper_core.sv @@
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        action, rx_byte, from_ring
// out_ch   out  valid/ready        out_byte, to_ring, last, checksum_error
// cfg_ch   in   valid/ready (=1)   index, data
//
// The front takes one item per cycle while the four-entry command queue has room.
// A host line end or re-stamped ring line drains as ID_LEN+4 bytes, one per cycle
// from the back while out_ch is ready; the front keeps taking items until the queue fills.
// With the queue empty, an accepted item is registered in the queue, then in the output register.
// Reset is synchronous; it clears line state, halt, queue and output valid.
// A stalled out_ch holds the output register and backs up the queue.
module ring_line_checksum_stamper_core #(
  parameter int MAX_LINE = rlcs_pkg::MAX_LINE_DEF,
  parameter int ID_LEN   = rlcs_pkg::ID_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rlcs_in_if.sink      in_ch,
  rlcs_out_if.source   out_ch,
  rlcs_cfg_if.sink     cfg_ch
);

  localparam int LW = $clog2(MAX_LINE);
  localparam int SW = $clog2(ID_LEN + 4);

  logic [rlcs_pkg::NODE_ID_W-1:0] node_id_r;
  logic [rlcs_pkg::WAIT_W-1:0]    wait_ticks_r;
  logic                           in_accept;
  logic                           push;
  logic                           pop;
  logic                           empty;
  logic                           full;
  logic                           busy;
  logic [SW-1:0]                  seq;
  rlcs_pkg::cmd_t                 push_cmd;
  rlcs_pkg::cmd_t                 head;
  rlcs_pkg::front_stat_t          stat;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !full;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= rlcs_pkg::NODE_ID_RST;
      wait_ticks_r <= rlcs_pkg::WAIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rlcs_pkg::CFG_NODE_ID: node_id_r <= cfg_ch.data;
        rlcs_pkg::CFG_WAIT:    wait_ticks_r <= cfg_ch.data[rlcs_pkg::WAIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rlcs_front #(
    .MAX_LINE (MAX_LINE),
    .LW       (LW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .action     (in_ch.action),
    .rx_byte    (in_ch.rx_byte),
    .from_ring  (in_ch.from_ring),
    .wait_ticks (wait_ticks_r),
    .push       (push),
    .cmd        (push_cmd),
    .stat       (stat)
  );

  rlcs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  rlcs_back #(
    .ID_LEN (ID_LEN),
    .SW     (SW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .node_id (node_id_r),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .busy    (busy),
    .seq     (seq),
    .out_ch  (out_ch)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into a full queue");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |-> (!stat.line_active && !stat.awaiting))
    else $error("halted with a line or return still open");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |=> stat.halted)
    else $error("halt cleared without reset");

  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (seq != '0 && seq <= SW'(ID_LEN + 3)))
    else $error("trailer sequence out of range");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !pop)
    else $error("queue popped during a trailer");

endmodule

@@ sv/rlcs_front.sv @@
module rlcs_front #(
  parameter int MAX_LINE = rlcs_pkg::MAX_LINE_DEF,
  parameter int LW       = $clog2(MAX_LINE)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          action,
  input  logic [7:0]                    rx_byte,
  input  logic                          from_ring,
  input  logic [rlcs_pkg::WAIT_W-1:0]   wait_ticks,
  output logic                          push,
  output rlcs_pkg::cmd_t                cmd,
  output rlcs_pkg::front_stat_t         stat
);

  logic                        line_active_r, line_active_nxt;
  logic                        line_is_ring_r, line_is_ring_nxt;
  logic                        awaiting_r, awaiting_nxt;
  logic [rlcs_pkg::WAIT_W-1:0] wait_count_r, wait_count_nxt;
  logic [7:0]                  held0_r, held0_nxt;
  logic [7:0]                  held1_r, held1_nxt;
  logic [1:0]                  held_count_r, held_count_nxt;
  logic [7:0]                  xor_r, xor_nxt;
  logic [LW-1:0]               len_r, len_nxt;
  logic                        halted_r, halted_nxt;

  always_comb begin
    logic          proceed;
    logic          term;
    logic [7:0]    xr;
    logic [LW-1:0] ln;
    logic [1:0]    hc;
    logic          dest;
    logic [4:0]    hv;
    logic [4:0]    lv;

    line_active_nxt  = line_active_r;
    line_is_ring_nxt = line_is_ring_r;
    awaiting_nxt     = awaiting_r;
    wait_count_nxt   = wait_count_r;
    held0_nxt        = held0_r;
    held1_nxt        = held1_r;
    held_count_nxt   = held_count_r;
    xor_nxt          = xor_r;
    len_nxt          = len_r;
    halted_nxt       = halted_r;
    push             = 1'b0;
    cmd              = '0;
    proceed          = 1'b0;
    term             = 1'b0;
    xr               = xor_r;
    ln               = len_r;
    hc               = held_count_r;
    dest             = !awaiting_r;
    hv               = rlcs_pkg::hex_val(held0_r);
    lv               = rlcs_pkg::hex_val(held1_r);

    if (accept && !halted_r) begin
      if (action) begin
        if (awaiting_r && !line_active_r) begin
          if (wait_count_r >= wait_ticks) begin
            awaiting_nxt = 1'b0;
          end else begin
            wait_count_nxt = wait_count_r + 1'b1;
          end
        end
      end else begin
        proceed = 1'b1;
        if (!line_active_r) begin
          if (awaiting_r && !from_ring) begin
            proceed = 1'b0;
          end else begin
            line_active_nxt  = 1'b1;
            line_is_ring_nxt = from_ring;
            xr               = 8'd0;
            ln               = '0;
            hc               = 2'd0;
          end
        end else if (from_ring != line_is_ring_r) begin
          proceed = 1'b0;
        end

        if (proceed) begin
          term = (rx_byte == rlcs_pkg::NL_CHAR) ||
                 (({1'b0, ln} + 1'b1) >= (LW+1)'(MAX_LINE));
          xor_nxt        = xr;
          len_nxt        = ln;
          held_count_nxt = hc;
          if (!line_is_ring_nxt) begin
            if (!term) begin
              push         = 1'b1;
              cmd.kind     = rlcs_pkg::CMD_BYTE;
              cmd.data     = rx_byte;
              cmd.to_ring  = 1'b1;
              xor_nxt      = xr ^ rx_byte;
              len_nxt      = ln + 1'b1;
            end else begin
              push            = 1'b1;
              cmd.kind        = rlcs_pkg::CMD_STAMP;
              cmd.data        = xr;
              cmd.to_ring     = 1'b1;
              line_active_nxt = 1'b0;
              awaiting_nxt    = 1'b1;
              wait_count_nxt  = '0;
            end
          end else if (!term) begin
            len_nxt = ln + 1'b1;
            if (hc >= 2'd2) begin
              push        = 1'b1;
              cmd.kind    = rlcs_pkg::CMD_BYTE;
              cmd.data    = held0_r;
              cmd.to_ring = dest;
              xor_nxt     = xr ^ held0_r;
              held0_nxt   = held1_r;
              held1_nxt   = rx_byte;
            end else begin
              if (hc == 2'd0) begin
                held0_nxt = rx_byte;
              end else begin
                held1_nxt = rx_byte;
              end
              held_count_nxt = hc + 2'd1;
            end
          end else begin
            push            = 1'b1;
            line_active_nxt = 1'b0;
            held_count_nxt  = 2'd0;
            if (hc < 2'd2 || !hv[4] || !lv[4] || {hv[3:0], lv[3:0]} != xr) begin
              cmd.kind     = rlcs_pkg::CMD_BYTE;
              cmd.err      = 1'b1;
              halted_nxt   = 1'b1;
              awaiting_nxt = 1'b0;
            end else if (awaiting_r) begin
              cmd.kind     = rlcs_pkg::CMD_BYTE;
              cmd.data     = rlcs_pkg::NL_CHAR;
              cmd.last     = 1'b1;
              awaiting_nxt = 1'b0;
            end else begin
              cmd.kind    = rlcs_pkg::CMD_STAMP;
              cmd.data    = xr;
              cmd.to_ring = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r  <= 1'b0;
      line_is_ring_r <= 1'b0;
      awaiting_r     <= 1'b0;
      wait_count_r   <= '0;
      held0_r        <= 8'd0;
      held1_r        <= 8'd0;
      held_count_r   <= 2'd0;
      xor_r          <= 8'd0;
      len_r          <= '0;
      halted_r       <= 1'b0;
    end else begin
      line_active_r  <= line_active_nxt;
      line_is_ring_r <= line_is_ring_nxt;
      awaiting_r     <= awaiting_nxt;
      wait_count_r   <= wait_count_nxt;
      held0_r        <= held0_nxt;
      held1_r        <= held1_nxt;
      held_count_r   <= held_count_nxt;
      xor_r          <= xor_nxt;
      len_r          <= len_nxt;
      halted_r       <= halted_nxt;
    end
  end

  assign stat.halted      = halted_r;
  assign stat.line_active = line_active_r;
  assign stat.awaiting    = awaiting_r;

endmodule

@@ sv/rlcs_cmd_fifo.sv @@
module rlcs_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rlcs_pkg::cmd_t push_cmd,
  input  logic           pop,
  output rlcs_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  rlcs_pkg::cmd_t               mem_r [rlcs_pkg::QDEPTH];
  logic [rlcs_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rlcs_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rlcs_pkg::QAW:0]       count_r, count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (rlcs_pkg::QAW+1)'(rlcs_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/rlcs_back.sv @@
module rlcs_back #(
  parameter int ID_LEN = rlcs_pkg::ID_LEN_DEF,
  parameter int SW     = $clog2(ID_LEN + 4),
  parameter int KW     = (ID_LEN > 1) ? $clog2(ID_LEN) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rlcs_pkg::NODE_ID_W-1:0]   node_id,
  input  rlcs_pkg::cmd_t                   head,
  input  logic                             empty,
  output logic                             pop,
  output logic                             busy,
  output logic [SW-1:0]                    seq,
  rlcs_out_if.source                       out_ch
);

  localparam logic [SW-1:0] SEQ_HI   = SW'(ID_LEN + 1);
  localparam logic [SW-1:0] SEQ_LO   = SW'(ID_LEN + 2);
  localparam logic [SW-1:0] SEQ_LAST = SW'(ID_LEN + 3);

  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          to_ring_r, to_ring_nxt;
  logic                          last_r, last_nxt;
  logic                          err_r, err_nxt;
  logic                          busy_r, busy_nxt;
  logic [SW-1:0]                 seq_r, seq_nxt;
  logic [7:0]                    sum_r, sum_nxt;
  logic [rlcs_pkg::ID_EXT_W-1:0] id_ext;
  logic [7:0]                    id_chars [ID_LEN];
  logic [7:0]                    id_xor;
  logic [SW-1:0]                 k_full;
  logic                          adv;

  assign id_ext = rlcs_pkg::ID_EXT_W'(node_id);
  assign k_full = seq_r - 1'b1;
  assign adv    = !out_valid_r || out_ch.ready;

  always_comb begin
    id_xor = 8'd0;
    for (int k = 0; k < ID_LEN; k++) begin
      id_chars[k] = id_ext[8*(ID_LEN-1-k) +: 8];
      id_xor      = id_xor ^ id_chars[k];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    to_ring_nxt   = to_ring_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    busy_nxt      = busy_r;
    seq_nxt       = seq_r;
    sum_nxt       = sum_r;
    pop           = 1'b0;
    if (adv) begin
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        to_ring_nxt   = 1'b1;
        last_nxt      = 1'b0;
        err_nxt       = 1'b0;
        seq_nxt       = seq_r + 1'b1;
        if (seq_r == SEQ_HI) begin
          out_byte_nxt = rlcs_pkg::hex_char(sum_r[7:4]);
        end else if (seq_r == SEQ_LO) begin
          out_byte_nxt = rlcs_pkg::hex_char(sum_r[3:0]);
        end else if (seq_r == SEQ_LAST) begin
          out_byte_nxt = rlcs_pkg::NL_CHAR;
          last_nxt     = 1'b1;
          busy_nxt     = 1'b0;
        end else begin
          out_byte_nxt = id_chars[k_full[KW-1:0]];
        end
      end else if (!empty) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        case (head.kind)
          rlcs_pkg::CMD_STAMP: begin
            out_byte_nxt = rlcs_pkg::SEP_CHAR;
            to_ring_nxt  = 1'b1;
            last_nxt     = 1'b0;
            err_nxt      = 1'b0;
            busy_nxt     = 1'b1;
            seq_nxt      = SW'(1);
            sum_nxt      = head.data ^ rlcs_pkg::SEP_CHAR ^ id_xor;
          end
          default: begin
            out_byte_nxt = head.data;
            to_ring_nxt  = head.to_ring;
            last_nxt     = head.last;
            err_nxt      = head.err;
          end
        endcase
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      seq_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      seq_r       <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    to_ring_r  <= to_ring_nxt;
    last_r     <= last_nxt;
    err_r      <= err_nxt;
    sum_r      <= sum_nxt;
  end

  assign busy                  = busy_r;
  assign seq                   = seq_r;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.to_ring        = to_ring_r;
  assign out_ch.last           = last_r;
  assign out_ch.checksum_error = err_r;

endmodule
